FILE: hdl/cda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date adder package
// Shared word types, codes, controller interface and calendar helpers.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 2;

  // Day counter must hold seven times the largest count.
  localparam int unsigned DCNT_W = 15;

  // floor(2^24 / 400); slightly low, so one corrective subtract is enough.
  localparam logic [15:0] RECIP_400 = 16'd41943;

  localparam logic [ACT_W-1:0] ACT_DAYS       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WEEKS      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MONTHS     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_YEARS      = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DECADES    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CENTURIES  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_MILLENNIA  = 3'd6;

  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_DATE  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_SATURATED = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] step_count;
  } cda_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic [STAT_W-1:0]  status;
  } cda_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic modr;
    logic check;
    logic step;
    logic finish;
  } cda_cmd_t;

  typedef struct packed {
    logic chk_step;
    logic cnt_zero;
    logic out_free;
  } cda_sts_t;

  // Leap test from the year modulo 400.
  function automatic logic is_leap(input logic [8:0] rem);
    logic rem_zero;
    logic on_century;
    rem_zero   = (rem == 9'd0);
    on_century = (rem == 9'd0) || (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
    return rem_zero || ((rem[1:0] == 2'b00) && !on_century);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/cda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date adder controller
// Sequences load, preparation, check, stepping and result hand-off.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cda_pkg::cda_sts_t sts,
  output cda_pkg::cda_cmd_t cmd
);
  import cda_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_MODR   = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_STEP   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MODR;
      end
      ST_MODR: begin
        cmd.modr  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.chk_step ? ST_STEP : ST_FINISH;
      end
      ST_STEP: begin
        if (sts.cnt_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/cda_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date adder datapath
// Date registers, leap residue, step counter and the output register.
// ----------------------------------------------------------------------------
module cda_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  cda_pkg::cda_in_t  in_data,
  output cda_pkg::cda_out_t out_data,
  output logic              out_valid,
  input  logic              out_ready,
  input  cda_pkg::cda_cmd_t cmd,
  output cda_pkg::cda_sts_t sts
);
  import cda_pkg::*;

  logic [ACT_W-1:0]   act_r;
  logic [DAY_W-1:0]   d_r;
  logic [MONTH_W-1:0] m_r;
  logic [YEAR_W-1:0]  y_r;
  logic [COUNT_W-1:0] n_r;
  logic [DCNT_W-1:0]  cnt_r;
  logic [7:0]         q_r;
  logic [8:0]         rem_r;
  logic [21:0]        prod_r;
  logic [STAT_W-1:0]  stat_r;
  cda_out_t           out_r;
  logic               out_valid_r, out_valid_nxt;

  logic [31:0]        q_mul;
  logic [9:0]         per_unit;
  logic [21:0]        prod_nxt;
  logic [DCNT_W-1:0]  cnt_init;
  logic [15:0]        rem_diff;
  logic [9:0]         rem_raw;
  logic [8:0]         rem_fix;
  logic [DAY_W-1:0]   len_cur;
  logic               bad_date;
  logic               year_act;
  logic [22:0]        year_sum;
  logic [8:0]         rem_inc;
  logic               at_dec;
  logic               at_max;
  logic [MONTH_W-1:0] m_next;
  logic [DAY_W-1:0]   len_next;

  assign q_mul = 32'(y_r) * 32'(RECIP_400);

  always_comb begin
    case (act_r)
      ACT_DECADES:   per_unit = 10'd10;
      ACT_CENTURIES: per_unit = 10'd100;
      ACT_MILLENNIA: per_unit = 10'd1000;
      default:       per_unit = 10'd1;
    endcase
  end

  assign prod_nxt = 22'(n_r) * 22'(per_unit);
  assign cnt_init = (act_r == ACT_WEEKS)
                    ? DCNT_W'(({3'b000, n_r} << 3) - {3'b000, n_r})
                    : DCNT_W'(n_r);

  assign rem_diff = y_r - 16'(16'(q_r) * 16'd400);
  assign rem_raw  = rem_diff[9:0];
  assign rem_fix  = (rem_raw >= 10'd400) ? 9'(rem_raw - 10'd400) : rem_raw[8:0];

  assign len_cur  = month_len(is_leap(rem_r), m_r);
  assign bad_date = (m_r == 4'd0) || (m_r > 4'd12) || (d_r == 5'd0) || (d_r > len_cur);
  assign year_act = (act_r >= ACT_YEARS) && (act_r <= ACT_MILLENNIA);
  assign year_sum = 23'(y_r) + 23'(prod_r);

  assign rem_inc  = (rem_r == 9'd399) ? 9'd0 : 9'(rem_r + 9'd1);
  assign at_dec   = (m_r == 4'd12);
  assign at_max   = (y_r == 16'hFFFF);
  assign m_next   = at_dec ? 4'd1 : 4'(m_r + 4'd1);
  assign len_next = month_len(at_dec ? is_leap(rem_inc) : is_leap(rem_r), m_next);

  assign sts.chk_step = !bad_date && (act_r <= ACT_MONTHS);
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_data.action;
      d_r    <= in_data.start_day;
      m_r    <= in_data.start_month;
      y_r    <= in_data.start_year;
      n_r    <= in_data.step_count;
      stat_r <= STATUS_OK;
    end
    if (cmd.prep) begin
      q_r    <= q_mul[31:24];
      prod_r <= prod_nxt;
      cnt_r  <= cnt_init;
    end
    if (cmd.modr) begin
      rem_r <= rem_fix;
    end
    if (cmd.check) begin
      if (bad_date) begin
        stat_r <= STATUS_BAD_DATE;
      end else if (year_act) begin
        if (year_sum > 23'(16'hFFFF)) begin
          y_r    <= 16'hFFFF;
          stat_r <= STATUS_SATURATED;
        end else begin
          y_r <= year_sum[15:0];
        end
      end
    end
    if (cmd.step) begin
      if (act_r == ACT_MONTHS) begin
        if (at_dec && at_max) begin
          stat_r <= STATUS_SATURATED;
          cnt_r  <= '0;
        end else begin
          m_r   <= m_next;
          cnt_r <= cnt_r - DCNT_W'(1);
          if (d_r > len_next) begin
            d_r <= len_next;
          end
          if (at_dec) begin
            y_r   <= y_r + 16'd1;
            rem_r <= rem_inc;
          end
        end
      end else begin
        if (d_r < len_cur) begin
          d_r   <= d_r + 5'd1;
          cnt_r <= cnt_r - DCNT_W'(1);
        end else if (at_dec && at_max) begin
          stat_r <= STATUS_SATURATED;
          cnt_r  <= '0;
        end else begin
          d_r   <= 5'd1;
          m_r   <= m_next;
          cnt_r <= cnt_r - DCNT_W'(1);
          if (at_dec) begin
            y_r   <= y_r + 16'd1;
            rem_r <= rem_inc;
          end
        end
      end
    end
    if (cmd.finish) begin
      out_r.end_day   <= d_r;
      out_r.end_month <= m_r;
      out_r.end_year  <= y_r;
      out_r.status    <= stat_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: hdl/calendar_date_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date adder
// Advances a Gregorian date by days, weeks, months or multiples of years.
// ----------------------------------------------------------------------------
// Day, week and month actions step once per day or month (count, or seven
// times count for weeks, up to 28665 steps); year actions, invalid dates
// and the unused action code skip the stepping loop.
// Throughput: one word at a time; the next word is taken the cycle after the
// result moves into the output register, and a held result stalls that move.
// Reset is synchronous, active low, and clears the controller and out_valid.
// ----------------------------------------------------------------------------
module calendar_date_adder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cda_pkg::cda_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cda_pkg::cda_out_t out_data
);
  import cda_pkg::*;

  // The controller issues at most one command per cycle; the datapath
  // answers with the few status bits the controller branches on.
  cda_cmd_t cmd;
  cda_sts_t sts;

  // The controller walks through load, a reciprocal multiply for the year
  // quotient by 400, the remainder correction, the validity check (which
  // also applies year-type actions), the stepping loop and the hand-off.
  cda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath keeps the year modulo 400 alongside the year, so the leap
  // rule is a few compares on a narrow value at every step. The output
  // register lets a finished word wait while the next one is worked on.
  cda_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: bench/tb_date_board_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder scoreboard
// Works out the advanced date for each accepted word and checks the results.
// ----------------------------------------------------------------------------
package tb_date_board_pkg;

  import cda_pkg::*;

  class date_board;

    cda_out_t    due_dates[$];
    int unsigned failures;
    int unsigned mismatches;

    function new();
      failures   = 0;
      mismatches = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned days_in_month(int unsigned y, int unsigned m);
      case (m)
        2: return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        1, 3, 5, 7, 8, 10, 12: return 31;
        default: return 0;
      endcase
    endfunction

    // Computes the date that the block should return for one input word.
    function cda_out_t advance_date(cda_in_t w);
      int unsigned d;
      int unsigned m;
      int unsigned y;
      int unsigned n;
      int unsigned steps;
      int unsigned span;
      int unsigned sum;
      logic [STAT_W-1:0] st;
      cda_out_t r;
      d  = w.start_day;
      m  = w.start_month;
      y  = w.start_year;
      n  = w.step_count;
      st = STATUS_OK;
      if (m < 1 || m > 12 || d == 0 || d > days_in_month(y, m)) begin
        st = STATUS_BAD_DATE;
      end else begin
        case (w.action)
          ACT_DAYS, ACT_WEEKS: begin
            steps = (w.action == ACT_WEEKS) ? n * 7 : n;
            for (int unsigned i = 0; i < steps; i++) begin
              if (d < days_in_month(y, m)) begin
                d++;
              end else if (m == 12) begin
                if (y >= 65535) begin
                  st = STATUS_SATURATED;
                  break;
                end
                y++;
                m = 1;
                d = 1;
              end else begin
                m++;
                d = 1;
              end
            end
          end
          ACT_MONTHS: begin
            for (int unsigned i = 0; i < n; i++) begin
              if (m == 12) begin
                if (y >= 65535) begin
                  st = STATUS_SATURATED;
                  break;
                end
                y++;
                m = 1;
              end else begin
                m++;
              end
              if (d > days_in_month(y, m)) d = days_in_month(y, m);
            end
          end
          ACT_YEARS, ACT_DECADES, ACT_CENTURIES, ACT_MILLENNIA: begin
            span = (w.action == ACT_YEARS) ? 1 : (w.action == ACT_DECADES) ? 10 :
                   (w.action == ACT_CENTURIES) ? 100 : 1000;
            sum  = y + n * span;
            if (sum > 65535) begin
              y  = 65535;
              st = STATUS_SATURATED;
            end else begin
              y = sum;
            end
          end
          default: ;
        endcase
      end
      r.end_day   = DAY_W'(d);
      r.end_month = MONTH_W'(m);
      r.end_year  = YEAR_W'(y);
      r.status    = st;
      return r;
    endfunction

    function void note_word(cda_in_t w);
      due_dates.push_back(advance_date(w));
    endfunction

    function void check_date(cda_out_t got);
      cda_out_t want;
      if (due_dates.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("result with none due: day %0d month %0d year %0d status %0d",
                   got.end_day, got.end_month, got.end_year, got.status);
        return;
      end
      want = due_dates.pop_front();
      if (got.end_day !== want.end_day || got.end_month !== want.end_month ||
          got.end_year !== want.end_year || got.status !== want.status) begin
        failures++;
        mismatches++;
        if (mismatches <= 10)
          $display("date mismatch: expected %0d/%0d/%0d st %0d, got %0d/%0d/%0d st %0d",
                   want.end_day, want.end_month, want.end_year, want.status,
                   got.end_day, got.end_month, got.end_year, got.status);
      end
    endfunction

    function int unsigned pending();
      return due_dates.size();
    endfunction

  endclass

endpackage

FILE: bench/tb_calendar_date_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date adder testbench
// Feeds directed and random dates through the adder under random idling on
// both channels and checks every result word against a scoreboard.
// ----------------------------------------------------------------------------
module tb_calendar_date_adder;

  import cda_pkg::*;
  import tb_date_board_pkg::*;

  // The block has no code for action 7; it must pass the date through.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  // The longest correct word is 4095 weeks, stepped one day at a time with no
  // acceptance on either side, so this limit leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 120000;
  localparam int unsigned RANDOM_WORDS = 115;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  cda_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cda_out_t out_data;

  // When set, neither side idles; used for one long stretch of the run.
  bit          quiet = 1'b0;
  int unsigned stall_cycles = 0;
  date_board   board = new();

  calendar_date_adder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver drops ready about 21 percent of the time unless the run is in
  // its quiet stretch.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 21);
  end

  // Handshakes are sampled at the falling edge, where every signal has
  // settled; a word seen here is taken at the following rising edge.
  always @(negedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_word(in_data);
    if (rst_n && out_valid && out_ready) board.check_date(out_data);
  end

  // Watchdog on cycles in which nothing moves on either channel.
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_calendar_date_adder: errors");
        $finish;
      end
    end
  end

  function automatic cda_in_t date_word(logic [ACT_W-1:0] act, int unsigned d,
                                        int unsigned m, int unsigned y,
                                        int unsigned n);
    cda_in_t w;
    w.action      = act;
    w.start_day   = DAY_W'(d);
    w.start_month = MONTH_W'(m);
    w.start_year  = YEAR_W'(y);
    w.step_count  = COUNT_W'(n);
    return w;
  endfunction

  // Stepping actions take one step per day or month, so their counts are
  // mostly small, with an occasional full-range one.
  function automatic int unsigned pick_count(logic [ACT_W-1:0] act);
    if (act == ACT_DAYS || act == ACT_WEEKS || act == ACT_MONTHS) begin
      if ($urandom_range(0, 24) == 0) return $urandom_range(0, 4095);
      return $urandom_range(0, 60);
    end
    return $urandom_range(0, 4095);
  endfunction

  // Presents one word and returns at the rising edge that takes it. Valid is
  // left high afterward, so a following word with no gap never sees valid
  // lowered and raised in the same step.
  task automatic send_word(input cda_in_t w);
    int unsigned gap;
    bit taken;
    gap = 0;
    while (!quiet && $urandom_range(0, 99) < 21) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  // Holds the sender back until every result due so far has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic send_random_date();
    logic [ACT_W-1:0] act;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned len;
    act = ACT_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 85) begin
      // Well-formed date, weighted toward the top years, century years and
      // month ends where the carries happen.
      case ($urandom_range(0, 9))
        0, 1: y = $urandom_range(65520, 65535);
        2: y = $urandom_range(0, 655) * 100;
        default: y = $urandom_range(0, 65535);
      endcase
      m   = $urandom_range(1, 12);
      len = board.days_in_month(y, m);
      d   = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
    end else begin
      y = $urandom_range(0, 65535);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    send_word(date_word(act, d, m, y, pick_count(act)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero count, and the leap rule on each side of the century exception.
    send_word(date_word(ACT_DAYS, 1, 1, 2000, 0));
    send_word(date_word(ACT_DAYS, 28, 2, 2000, 1));
    send_word(date_word(ACT_DAYS, 28, 2, 1900, 1));
    send_word(date_word(ACT_DAYS, 28, 2, 2024, 1));
    // Largest counts for the stepping actions.
    send_word(date_word(ACT_DAYS, 15, 6, 1999, 4095));
    send_word(date_word(ACT_WEEKS, 29, 2, 0, 4095));
    send_word(date_word(ACT_MONTHS, 31, 1, 0, 4095));
    // Stepping into the top year stops at the last reachable date.
    send_word(date_word(ACT_WEEKS, 28, 12, 65535, 1));
    send_word(date_word(ACT_DAYS, 31, 12, 65535, 1));
    send_word(date_word(ACT_MONTHS, 30, 11, 65535, 3));
    // Month steps clamp the day to the shorter month.
    send_word(date_word(ACT_MONTHS, 31, 1, 2023, 1));
    // Year actions keep day and month, even 29 February in a common year.
    send_word(date_word(ACT_YEARS, 29, 2, 2024, 1));
    send_word(date_word(ACT_DECADES, 17, 9, 0, 4095));
    send_word(date_word(ACT_CENTURIES, 1, 1, 0, 4095));
    send_word(date_word(ACT_MILLENNIA, 1, 1, 0, 65));
    send_word(date_word(ACT_MILLENNIA, 1, 1, 0, 66));
    send_word(date_word(ACT_YEARS, 5, 5, 65535, 4095));
    send_word(date_word(ACT_YEARS, 5, 5, 65535, 0));
    // The unused action code leaves a valid date alone.
    send_word(date_word(ACT_UNUSED, 31, 12, 65535, 4095));
    // Invalid start dates come back unchanged.
    send_word(date_word(ACT_DAYS, 0, 0, 0, 0));
    send_word(date_word(ACT_DAYS, 10, 13, 2000, 5));
    send_word(date_word(ACT_MONTHS, 0, 3, 2000, 5));
    send_word(date_word(ACT_WEEKS, 31, 4, 2000, 5));
    send_word(date_word(ACT_YEARS, 29, 2, 1900, 5));
    send_word(date_word(ACT_UNUSED, 31, 15, 65535, 4095));

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 40) drain_results();
      quiet = (i >= 70 && i < 105);
      send_random_date();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("tb_calendar_date_adder: clean");
    end else begin
      $display("tb_calendar_date_adder: errors");
    end
    $finish;
  end

endmodule
